@@ sv/mbps_pkg.sv @@
// Shared types, register indexes and status codes for the masked byte pattern scanner.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mbps_pkg;

	localparam int REG_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int ADDR_W     = 64;
	localparam int MOFF_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int CNT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_SUCCESS       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MATCH      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MULTIPLE      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID_PAT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID_RANGE = 3'd4;

	localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
	localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
	localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

	typedef struct packed {
		logic [8*REG_BYTES-1:0] bytes;
		logic [REG_BYTES-1:0]   mask;
		logic [LEN_W-1:0]       len;
	} pat_cfg_t;

	function automatic logic len_valid(input logic [LEN_W-1:0] len, input int unsigned limit);
		return (len != '0) && (32'(len) <= limit);
	endfunction

endpackage

`default_nettype wire

@@ sv/masked_byte_pattern_scanner.sv @@
// Top level of the masked byte pattern scanner: configuration registers, input register,
// and the scan and result stages. Depends on mbps_pkg, mbps_scan and mbps_result.
//
// Usage: the buffer is streamed one byte per transaction on the input channel
// (in_valid/in_ready, byte_value, last_byte). Only the transaction that carries
// last_byte produces a result transaction on the output channel (out_valid/out_ready,
// status, match_offset, match_address); other bytes produce none.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data, one register per
// cycle, while the block holds no buffer in flight. Indexes: 0 pattern bytes 0 to 7,
// 1 pattern bytes 8 to 15, 2 compare mask, 3 pattern length, 4 base address.
// A last byte's result moves through the input, end-of-buffer and output registers.
// Throughput: one byte per cycle while a last byte is not held by a stall, set by the
// combinational window compare and counter update in the scan stage.
// Reset clears all configuration registers, the scan counters and every stage's valid.
// When the receiver stalls, the result waits in the output register and a second result
// waits in the stage before it; bytes that are not last keep flowing until a third
// last byte reaches the input register.
`default_nettype none

module masked_byte_pattern_scanner #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       byte_value,
	input  wire logic                             last_byte,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [mbps_pkg::STATUS_W-1:0]         status,
	output logic [mbps_pkg::MOFF_W-1:0]           match_offset,
	output logic [mbps_pkg::ADDR_W-1:0]           match_address
);
	import mbps_pkg::*;

	pat_cfg_t               pcfg_q;
	logic [ADDR_W-1:0]      base_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   adv_s1;
	logic                   s2_free;
	logic [OFFSET_BITS:0]   snap_seen;
	logic [CNT_W-1:0]       snap_count;
	logic [OFFSET_BITS-1:0] snap_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcfg_q <= '0;
			base_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PAT_LOW: begin
					pcfg_q.bytes[63:0] <= cfg_data;
				end
				CFG_PAT_HIGH: begin
					pcfg_q.bytes[127:64] <= cfg_data;
				end
				CFG_MASK: begin
					pcfg_q.mask <= cfg_data[REG_BYTES-1:0];
				end
				CFG_LENGTH: begin
					pcfg_q.len <= cfg_data[LEN_W-1:0];
				end
				CFG_BASE: begin
					base_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!last_s1 || s2_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	mbps_scan #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv_s1),
		.byte_in    (byte_s1),
		.last_in    (last_s1),
		.pcfg       (pcfg_q),
		.snap_seen  (snap_seen),
		.snap_count (snap_count),
		.snap_first (snap_first)
	);

	mbps_result #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.snap_load      (adv_s1 && last_s1),
		.snap_seen      (snap_seen),
		.snap_count     (snap_count),
		.snap_first     (snap_first),
		.pattern_length (pcfg_q.len),
		.base_address   (base_q),
		.out_ready      (out_ready),
		.s2_free        (s2_free),
		.out_valid      (out_valid),
		.status         (status),
		.match_offset   (match_offset),
		.match_address  (match_address)
	);

endmodule

`default_nettype wire

@@ sv/mbps_scan.sv @@
// Byte window, masked pattern compare and per-buffer match counters.
// Depends on mbps_pkg for the pattern configuration type and the length check.
`default_nettype none

module mbps_scan #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic [7:0]              byte_in,
	input  wire logic                    last_in,
	input  wire mbps_pkg::pat_cfg_t      pcfg,
	output logic [OFFSET_BITS:0]         snap_seen,
	output logic [mbps_pkg::CNT_W-1:0]   snap_count,
	output logic [OFFSET_BITS-1:0]       snap_first
);
	import mbps_pkg::*;

	localparam int SW        = OFFSET_BITS + 1;
	localparam int WIN_IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_LIMIT = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
	localparam logic [SW-1:0] SEEN_LIMIT = (SW'(1) << OFFSET_BITS) | SW'(1);

	logic [7:0]             window_q [MAX_PATTERN];
	logic [7:0]             win_nx   [MAX_PATTERN];
	logic [SW-1:0]          seen_q;
	logic [CNT_W-1:0]       count_q;
	logic [OFFSET_BITS-1:0] first_q;
	logic [SW-1:0]          seen_nx;
	logic [CNT_W-1:0]       count_nx;
	logic [OFFSET_BITS-1:0] first_nx;
	logic                   win_hit;
	logic                   check;
	logic                   hit;
	logic [6:0]             slot;

	always_comb begin
		win_nx[0] = byte_in;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_nx[k] = window_q[k-1];
		end
	end

	// Pattern byte i lines up with window slot len-1-i, slot zero being the newest byte.
	always_comb begin
		win_hit = 1'b1;
		slot    = '0;
		for (int i = 0; i < LEN_LIMIT; i++) begin
			slot = 7'(pcfg.len) - 7'(i + 1);
			if (pcfg.mask[i] && (7'(i) < 7'(pcfg.len)) && (slot < 7'(MAX_PATTERN))) begin
				if (win_nx[slot[WIN_IW-1:0]] != pcfg.bytes[8*i +: 8]) begin
					win_hit = 1'b0;
				end
			end
		end
	end

	assign seen_nx  = (seen_q < SEEN_LIMIT) ? seen_q + SW'(1) : seen_q;
	assign check    = len_valid(pcfg.len, LEN_LIMIT) && (seen_nx < SEEN_LIMIT) &&
	                  (seen_nx >= SW'(pcfg.len));
	assign hit      = check && win_hit;
	assign count_nx = (hit && (count_q != CNT_MANY)) ? count_q + CNT_ONE : count_q;
	assign first_nx = (hit && (count_q == CNT_NONE)) ?
	                  OFFSET_BITS'(seen_nx - SW'(pcfg.len)) : first_q;

	assign snap_seen  = seen_nx;
	assign snap_count = count_nx;
	assign snap_first = first_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				window_q[k] <= '0;
			end
			seen_q  <= '0;
			count_q <= CNT_NONE;
			first_q <= '0;
		end else if (advance) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				window_q[k] <= win_nx[k];
			end
			if (last_in) begin
				seen_q  <= '0;
				count_q <= CNT_NONE;
				first_q <= '0;
			end else begin
				seen_q  <= seen_nx;
				count_q <= count_nx;
				first_q <= first_nx;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/mbps_result.sv @@
// End-of-buffer stage and output register: status priority and match address.
// Depends on mbps_pkg for status codes and the length check.
`default_nettype none

module mbps_result #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          snap_load,
	input  wire logic [OFFSET_BITS:0]          snap_seen,
	input  wire logic [mbps_pkg::CNT_W-1:0]    snap_count,
	input  wire logic [OFFSET_BITS-1:0]        snap_first,
	input  wire logic [mbps_pkg::LEN_W-1:0]    pattern_length,
	input  wire logic [mbps_pkg::ADDR_W-1:0]   base_address,
	input  wire logic                          out_ready,
	output logic                               s2_free,
	output logic                               out_valid,
	output logic [mbps_pkg::STATUS_W-1:0]      status,
	output logic [mbps_pkg::MOFF_W-1:0]        match_offset,
	output logic [mbps_pkg::ADDR_W-1:0]        match_address
);
	import mbps_pkg::*;

	localparam int SW        = OFFSET_BITS + 1;
	localparam int LEN_LIMIT = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
	localparam logic [SW-1:0] SEEN_SPAN = SW'(1) << OFFSET_BITS;

	logic                   valid_s2;
	logic [SW-1:0]          seen_s2;
	logic [CNT_W-1:0]       count_s2;
	logic [OFFSET_BITS-1:0] first_s2;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [MOFF_W-1:0]      offset_q;
	logic [ADDR_W-1:0]      address_q;
	logic                   out_free;
	logic [ADDR_W:0]        end_sum;
	logic [ADDR_W-1:0]      addr_sum;
	logic [STATUS_W-1:0]    status_nx;
	logic [MOFF_W-1:0]      offset_nx;
	logic [ADDR_W-1:0]      address_nx;

	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	assign end_sum  = {1'b0, base_address} + (ADDR_W + 1)'(seen_s2);
	assign addr_sum = base_address + ADDR_W'(first_s2);

	always_comb begin
		offset_nx  = '0;
		address_nx = '0;
		priority if (!len_valid(pattern_length, LEN_LIMIT)) begin
			status_nx = ST_INVALID_PAT;
		end else if ((base_address == '0) || end_sum[ADDR_W] || (seen_s2 > SEEN_SPAN)) begin
			status_nx = ST_INVALID_RANGE;
		end else if ((seen_s2 < SW'(pattern_length)) || (count_s2 == CNT_NONE)) begin
			status_nx = ST_NO_MATCH;
		end else if (count_s2 != CNT_ONE) begin
			status_nx = ST_MULTIPLE;
		end else begin
			status_nx  = ST_SUCCESS;
			offset_nx  = MOFF_W'(first_s2);
			address_nx = addr_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= snap_load;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && snap_load) begin
			seen_s2  <= snap_seen;
			count_s2 <= snap_count;
			first_s2 <= snap_first;
		end
		if (out_free && valid_s2) begin
			status_q  <= status_nx;
			offset_q  <= offset_nx;
			address_q <= address_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign match_offset  = offset_q;
	assign match_address = address_q;

endmodule

`default_nettype wire

@@ sv/mbps_checker.sv @@
// Port-level checks on the result channel of the masked byte pattern scanner.
// Depends on mbps_pkg for status codes; bound to masked_byte_pattern_scanner below.
`default_nettype none

module mbps_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [mbps_pkg::STATUS_W-1:0] status,
	input wire logic [mbps_pkg::MOFF_W-1:0]   match_offset,
	input wire logic [mbps_pkg::ADDR_W-1:0]   match_address
);
	import mbps_pkg::*;

	// A stalled result transaction holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(match_offset) && $stable(match_address))
		else $error("result transaction changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_INVALID_RANGE))
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_SUCCESS) |-> (match_offset == '0) && (match_address == '0))
		else $error("offset or address nonzero on a failed search");

	// A unique match lies inside a valid range, so its address can never be zero.
	a_success_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SUCCESS) |-> (match_address != '0))
		else $error("zero address reported with a unique match");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);

`default_nettype wire

@@ test/mbps_checker.sv @@
// Checker for the masked byte pattern scanner: watches the register port and both channels,
// predicts each scan result and compares it with what the block returns.
// Depends on mbps_pkg for widths, register indexes and status codes.

module mbps_scoreboard #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [7:0]                        byte_value,
	input  logic                              last_byte,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [mbps_pkg::STATUS_W-1:0]     status,
	input  logic [mbps_pkg::MOFF_W-1:0]       match_offset,
	input  logic [mbps_pkg::ADDR_W-1:0]       match_address,
	output int                                fail_count,
	output int                                pending,
	output int                                results_checked,
	output logic [4:0]                        status_seen
);
	import mbps_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MOFF_W-1:0]   offset;
		logic [ADDR_W-1:0]   address;
	} scan_result_t;

	localparam int LEN_CAP = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
	localparam longint unsigned OFFSET_SPAN = 64'd1 << OFFSET_BITS;
	localparam longint unsigned SEEN_CAP = OFFSET_SPAN + 1;

	scan_result_t expected_results[$];

	logic [8*REG_BYTES-1:0] pat_bytes = '0;
	logic [REG_BYTES-1:0]   pat_mask  = '0;
	logic [LEN_W-1:0]       pat_len   = '0;
	logic [ADDR_W-1:0]      base_addr = '0;

	logic [7:0]        window [MAX_PATTERN];
	longint unsigned   seen      = 0;
	longint unsigned   first_off = 0;
	int unsigned       hits      = 0;

	int         n_fail    = 0;
	int         n_pending = 0;
	int         n_checked = 0;
	logic [4:0] seen_mask = '0;

	assign fail_count      = n_fail;
	assign pending         = n_pending;
	assign results_checked = n_checked;
	assign status_seen     = seen_mask;

	task automatic clear_scan();
		int i;
		for (i = 0; i < MAX_PATTERN; i++) window[i] = '0;
		seen      = 0;
		first_off = 0;
		hits      = 0;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic last);
		scan_result_t     r;
		logic             hit;
		logic             len_ok;
		logic [ADDR_W:0]  end_addr;
		int               i;
		int               len;
		for (i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
		window[0] = b;
		if (seen < SEEN_CAP) seen++;
		len    = int'(pat_len);
		len_ok = (len != 0) && (len <= LEN_CAP);
		if (len_ok && seen < SEEN_CAP && seen >= longint'(len)) begin
			hit = 1'b1;
			for (i = 0; i < len; i++) begin
				if (pat_mask[i] && window[len-1-i] != pat_bytes[8*i +: 8]) hit = 1'b0;
			end
			if (hit) begin
				if (hits == 0) first_off = seen - longint'(len);
				if (hits < 2) hits++;
			end
		end
		if (last) begin
			r        = '0;
			end_addr = {1'b0, base_addr} + (ADDR_W+1)'(seen);
			if (!len_ok) begin
				r.status = ST_INVALID_PAT;
			end else if (base_addr == '0 || end_addr[ADDR_W] || seen > OFFSET_SPAN) begin
				r.status = ST_INVALID_RANGE;
			end else if (seen < longint'(len) || hits == 0) begin
				r.status = ST_NO_MATCH;
			end else if (hits > 1) begin
				r.status = ST_MULTIPLE;
			end else begin
				r.status  = ST_SUCCESS;
				r.offset  = first_off[MOFF_W-1:0];
				r.address = base_addr + first_off;
			end
			expected_results.insert(expected_results.size(), r);
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t exp_r;
		if (!arst_n) begin
			pat_bytes = '0;
			pat_mask  = '0;
			pat_len   = '0;
			base_addr = '0;
			clear_scan();
			expected_results.delete();
			n_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("Result transaction with none expected: status %0d, match_offset %0d",
						status, match_offset);
					n_fail++;
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						n_fail++;
					end
					if (match_offset !== exp_r.offset) begin
						$error("match_offset: expected %0d, got %0d", exp_r.offset, match_offset);
						n_fail++;
					end
					if (match_address !== exp_r.address) begin
						$error("match_address: expected %h, got %h", exp_r.address, match_address);
						n_fail++;
					end
					n_checked++;
					seen_mask[exp_r.status] = 1'b1;
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PAT_LOW:  pat_bytes[63:0]   = cfg_data;
					CFG_PAT_HIGH: pat_bytes[127:64] = cfg_data;
					CFG_MASK:     pat_mask          = cfg_data[REG_BYTES-1:0];
					CFG_LENGTH:   pat_len           = cfg_data[LEN_W-1:0];
					CFG_BASE:     base_addr         = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) scan_byte(byte_value, last_byte);
			n_pending = expected_results.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// Top of the masked byte pattern scanner test: clock, reset, register writes and byte stimulus,
// random stalls on both channels, and the final verdict.
// Depends on mbps_pkg, masked_byte_pattern_scanner and mbps_scoreboard.

module testbench;
	import mbps_pkg::*;

	localparam int N_ITEMS     = 1900;
	localparam int PHASE_BYTES = 110;
	localparam longint LIMIT   = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic [ADDR_W-1:0] BASE_NEAR_TOP = 64'hFFFF_FFFF_FFFF_FFE0;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic [7:0]            byte_value  = '0;
	logic                  last_byte   = 1'b0;
	logic                  out_ready   = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [STATUS_W-1:0]   status;
	logic [MOFF_W-1:0]     match_offset;
	logic [ADDR_W-1:0]     match_address;

	int         fail_count;
	int         pending;
	int         results_checked;
	logic [4:0] status_seen;

	bit     no_idle   = 1'b0;
	bit     long_hold = 1'b0;
	bit     short_bufs = 1'b0;
	longint cycles    = 0;
	int     bytes_sent = 0;
	int     n_buffers  = 0;
	int     n_settings = 0;

	logic [8*REG_BYTES-1:0] cur_pat  = '0;
	logic [REG_BYTES-1:0]   cur_mask = '0;
	logic [LEN_W-1:0]       cur_len  = '0;
	logic [ADDR_W-1:0]      cur_base = '0;
	logic [7:0]             stream_q[$];

	always #4 clk = ~clk;

	masked_byte_pattern_scanner u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .match_offset(match_offset), .match_address(match_address)
	);

	mbps_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .match_offset(match_offset), .match_address(match_address),
		.fail_count(fail_count), .pending(pending),
		.results_checked(results_checked), .status_seen(status_seen)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Run stopped at cycle %0d with %0d results outstanding.", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver stalls at random, and once holds off long enough for the block to fill up.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ready = 1'b0;
			end else begin
				out_ready = no_idle || ($urandom_range(99) >= 6);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic load_pattern(input logic [8*REG_BYTES-1:0] pat, input logic [REG_BYTES-1:0] mask,
			input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] base);
		write_reg(CFG_PAT_LOW, pat[63:0]);
		write_reg(CFG_PAT_HIGH, pat[127:64]);
		write_reg(CFG_MASK, CFG_DATA_W'(mask));
		write_reg(CFG_LENGTH, CFG_DATA_W'(len));
		write_reg(CFG_BASE, base);
		cur_pat  = pat;
		cur_mask = mask;
		cur_len  = len;
		cur_base = base;
		n_settings++;
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic last);
		if (!no_idle && $urandom_range(99) < 6) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		byte_value = b;
		last_byte  = last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic feed_buffer();
		int i;
		for (i = 0; i < stream_q.size(); i++) feed_byte(stream_q[i], i == stream_q.size() - 1);
		in_valid = 1'b0;
		n_buffers++;
	endtask

	task automatic feed_list(input logic [7:0] bytes[$]);
		stream_q = bytes;
		feed_buffer();
	endtask

	// Background bytes are either fully random or drawn from the pattern itself, and up to two
	// copies of the pattern, keeping the background bytes at wildcard positions, are planted on top.
	task automatic make_buffer(input int n, input bit noise);
		int i;
		int k;
		int pos;
		int plen;
		int pick;
		bit narrow;
		plen = (cur_len >= 1 && cur_len <= REG_BYTES) ? int'(cur_len) : 0;
		narrow = !noise && $urandom_range(1);
		stream_q.delete();
		for (i = 0; i < n; i++) begin
			if (narrow && plen > 0) begin
				pick = $urandom_range(plen - 1);
				stream_q.insert(stream_q.size(), cur_pat[8*pick +: 8]);
			end else begin
				stream_q.insert(stream_q.size(), 8'($urandom));
			end
		end
		if (!noise && plen > 0 && n >= plen) begin
			for (k = $urandom_range(2); k > 0; k--) begin
				pos = $urandom_range(n - plen);
				for (i = 0; i < plen; i++) begin
					if (cur_mask[i]) stream_q[pos+i] = cur_pat[8*i +: 8];
				end
			end
		end
	endtask

	task automatic new_setting(input int phase);
		logic [8*REG_BYTES-1:0] pat;
		logic [REG_BYTES-1:0]   mask;
		logic [LEN_W-1:0]       len;
		logic [ADDR_W-1:0]      base;
		int r;
		pat = {$urandom, $urandom, $urandom, $urandom};
		r = $urandom_range(99);
		len = (r < 8) ? LEN_W'($urandom) : LEN_W'($urandom_range(1, REG_BYTES));
		r = $urandom_range(99);
		mask = (r < 15) ? '1 : (r < 22) ? '0 : REG_BYTES'($urandom);
		r = $urandom_range(99);
		base = (r < 5) ? '0 : (r < 10) ? BASE_NEAR_TOP : {$urandom, $urandom};
		case (phase)
			0: begin len = LEN_W'(REG_BYTES); mask = '1; end
			1: begin len = LEN_W'(1); mask = '1; end
			2: begin len = LEN_W'(REG_BYTES); mask = '0; end
			3: len = '0;
			4: len = '1;
			5: begin len = LEN_W'(3); base = '0; end
			6: begin len = LEN_W'(2); base = '1; end
			7: begin len = LEN_W'(4); base = BASE_NEAR_TOP; end
			8: pat = '1;
			9: pat = '0;
			10: begin len = LEN_W'(1); mask = '1; end
			default: ;
		endcase
		load_pattern(pat, mask, len, base);
	endtask

	initial begin
		logic [7:0] one_byte[$];
		int start;
		int pstart;
		int phase;
		int plen;
		int n;
		int r;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers still at their reset values: zero length is an invalid pattern.
		one_byte = '{8'h00};
		feed_list(one_byte);
		wait_drained();
		write_reg(CFG_SPARE, '1);
		write_reg(CFG_LENGTH, CFG_DATA_W'(5'd17));
		n_settings++;
		one_byte = '{8'hFF};
		feed_list(one_byte);

		wait_drained();
		load_pattern(128'h0000_0000_0000_FF00, 16'h0003, 5'd2, '0);
		feed_list('{8'h00, 8'hFF});
		wait_drained();
		load_pattern(128'h0000_0000_0000_FF00, 16'h0003, 5'd2, '1);
		feed_list('{8'h00, 8'hFF});
		wait_drained();
		load_pattern({64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FF00}, 16'h0003, 5'd2,
			64'h1000);
		feed_list('{8'h00, 8'hFF});
		one_byte = '{8'h00};
		feed_list(one_byte);
		feed_list('{8'h00, 8'hFF, 8'h00, 8'hFF});
		feed_list('{8'hFF, 8'hFF, 8'h00});
		feed_list('{8'hFF, 8'h00, 8'hFF});
		wait_drained();
		write_reg(CFG_MASK, CFG_DATA_W'(16'h0002));
		n_settings++;
		feed_list('{8'h37, 8'hFF});

		start = bytes_sent;
		phase = 0;
		while (bytes_sent - start < N_ITEMS) begin
			wait_drained();
			new_setting(phase);
			no_idle    = (phase == 11);
			short_bufs = (phase == 10);
			if (phase == 10) long_hold = 1'b1;
			pstart = bytes_sent;
			while (bytes_sent - pstart < PHASE_BYTES) begin
				plen = (cur_len >= 1 && cur_len <= REG_BYTES) ? int'(cur_len) : 4;
				r = $urandom_range(99);
				if (short_bufs) n = $urandom_range(1, 3);
				else if (r < 10) n = $urandom_range(1, (plen > 1) ? plen - 1 : 1);
				else if (r < 85) n = $urandom_range(plen, plen + 20);
				else n = $urandom_range(20, 60);
				make_buffer(n, $urandom_range(99) < 10);
				feed_buffer();
			end
			phase++;
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (10) @(negedge clk);
		$display("Streamed %0d bytes in %0d buffers under %0d register settings.",
			bytes_sent, n_buffers, n_settings);
		$display("Compared %0d scan results; status codes seen, one bit per code: %b.",
			results_checked, status_seen);
		if (fail_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
sv/mbps_pkg.sv
sv/mbps_scan.sv
sv/mbps_result.sv
sv/masked_byte_pattern_scanner.sv
sv/mbps_checker.sv
test/mbps_checker.sv
test/testbench.sv
